// ===== sv/pif_pkg.sv =====
// Shared types, element ids and CRC-16 helper for the probe-request
// element fingerprint block. No dependencies.
package pif_pkg;

  typedef struct packed {
    logic [7:0] ie_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ht_fingerprint;
    logic [15:0] vht_fingerprint;
    logic [15:0] rates_fingerprint;
    logic [15:0] extcap_fingerprint;
    logic [15:0] vendor_fingerprint;
    logic [15:0] combined_fingerprint;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } parse_phase_t;

  localparam logic [7:0]  ID_RATES      = 8'd1;
  localparam logic [7:0]  ID_HT         = 8'd45;
  localparam logic [7:0]  ID_EXTCAP     = 8'd127;
  localparam logic [7:0]  ID_VHT        = 8'd191;
  localparam logic [7:0]  ID_VENDOR     = 8'd221;
  localparam logic [7:0]  LIM_HT        = 8'd32;
  localparam logic [7:0]  LIM_SHORT     = 8'd16;
  localparam logic [8:0]  VENDOR_BUDGET = 9'd64;
  localparam logic [7:0]  VENDOR_PREFIX = 8'd8;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/pif_parse.sv =====
// Element parser and fingerprint state: one byte per step, result word
// formed from the updated state. Depends on pif_pkg.
module pif_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pif_pkg::in_item_t   item,
  output pif_pkg::out_item_t  result
);

  pif_pkg::parse_phase_t phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  seen_r, seen_nxt, seen_inc;
  logic [15:0] ecrc_r, ecrc_nxt;
  logic [15:0] ht_r, ht_nxt;
  logic [15:0] vht_r, vht_nxt;
  logic [15:0] rates_r, rates_nxt;
  logic [15:0] ext_r, ext_nxt;
  logic [5:0]  kept_r, kept_nxt;
  logic [15:0] vcom_r, vcom_nxt;
  logic [15:0] vwork_r, vwork_nxt;
  logic        fin;
  logic [15:0] kind_val;
  logic [8:0]  vsum;

  assign seen_inc = seen_r + 8'd1;
  assign fin = ((phase_r == pif_pkg::PH_LEN) && (item.ie_byte == 8'd0)) ||
               ((phase_r == pif_pkg::PH_BODY) && (seen_inc == len_r));

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      pif_pkg::PH_ID:   phase_nxt = pif_pkg::PH_LEN;
      pif_pkg::PH_LEN:  phase_nxt = (item.ie_byte == 8'd0) ? pif_pkg::PH_ID : pif_pkg::PH_BODY;
      pif_pkg::PH_BODY: phase_nxt = (seen_inc == len_r) ? pif_pkg::PH_ID : pif_pkg::PH_BODY;
      default:          phase_nxt = pif_pkg::PH_ID;
    endcase
  end

  always_comb begin
    id_nxt    = id_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    ecrc_nxt  = ecrc_r;
    vwork_nxt = vwork_r;
    ht_nxt    = ht_r;
    vht_nxt   = vht_r;
    rates_nxt = rates_r;
    ext_nxt   = ext_r;
    kept_nxt  = kept_r;
    vcom_nxt  = vcom_r;
    case (phase_r)
      pif_pkg::PH_ID: begin
        id_nxt = item.ie_byte;
      end
      pif_pkg::PH_LEN: begin
        len_nxt   = item.ie_byte;
        seen_nxt  = 8'd0;
        ecrc_nxt  = pif_pkg::CRC_INIT;
        vwork_nxt = vcom_r;
      end
      pif_pkg::PH_BODY: begin
        ecrc_nxt = pif_pkg::crc_byte(ecrc_r, item.ie_byte);
        if (id_r == pif_pkg::ID_VENDOR && seen_r < pif_pkg::VENDOR_PREFIX) begin
          vwork_nxt = pif_pkg::crc_byte(vwork_r, item.ie_byte);
        end
        seen_nxt = seen_inc;
      end
      default: ;
    endcase
    kind_val = (len_nxt == 8'd0) ? 16'd0 : ecrc_nxt;
    vsum = {3'b000, kept_r} + {1'b0, len_nxt};
    if (fin) begin
      if (id_r == pif_pkg::ID_HT && len_nxt <= pif_pkg::LIM_HT) ht_nxt = kind_val;
      if (id_r == pif_pkg::ID_VHT && len_nxt <= pif_pkg::LIM_SHORT) vht_nxt = kind_val;
      if (id_r == pif_pkg::ID_RATES && len_nxt <= pif_pkg::LIM_SHORT) rates_nxt = kind_val;
      if (id_r == pif_pkg::ID_EXTCAP && len_nxt <= pif_pkg::LIM_SHORT) ext_nxt = kind_val;
      if (id_r == pif_pkg::ID_VENDOR && vsum < pif_pkg::VENDOR_BUDGET) begin
        vcom_nxt = vwork_nxt;
        kept_nxt = kept_r + ((len_nxt < pif_pkg::VENDOR_PREFIX) ? len_nxt[5:0]
                                                                : pif_pkg::VENDOR_PREFIX[5:0]);
      end
    end
  end

  always_comb begin
    result.ht_fingerprint       = ht_nxt;
    result.vht_fingerprint      = vht_nxt;
    result.rates_fingerprint    = rates_nxt;
    result.extcap_fingerprint   = ext_nxt;
    result.vendor_fingerprint   = (kept_nxt != 6'd0) ? vcom_nxt : 16'd0;
    result.combined_fingerprint = (ht_nxt ^ vht_nxt) + (rates_nxt ^ ext_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r <= pif_pkg::PH_ID;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      seen_r  <= 8'd0;
      ecrc_r  <= pif_pkg::CRC_INIT;
      ht_r    <= 16'd0;
      vht_r   <= 16'd0;
      rates_r <= 16'd0;
      ext_r   <= 16'd0;
      kept_r  <= 6'd0;
      vcom_r  <= pif_pkg::CRC_INIT;
      vwork_r <= pif_pkg::CRC_INIT;
    end else if (step) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      ecrc_r  <= ecrc_nxt;
      ht_r    <= ht_nxt;
      vht_r   <= vht_nxt;
      rates_r <= rates_nxt;
      ext_r   <= ext_nxt;
      kept_r  <= kept_nxt;
      vcom_r  <= vcom_nxt;
      vwork_r <= vwork_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> phase_r == pif_pkg::PH_ID && kept_r == 6'd0 &&
                               ht_r == 16'd0 && vcom_r == pif_pkg::CRC_INIT)
    else $error("state not cleared after last byte");

  a_kinds_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(ht_r) && $stable(vht_r) && $stable(rates_r) && $stable(ext_r) &&
              $stable(kept_r))
    else $error("fingerprint state changed without a byte");

  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pif_pkg::PH_BODY |-> seen_r < len_r)
    else $error("body count passed element length");

endmodule

// ===== sv/pif_out_stage.sv =====
// Result register with valid/stall hold for the fingerprint block.
// Depends on pif_pkg.
module pif_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  pif_pkg::out_item_t d,
  input  logic               out_stall,
  output logic               out_valid,
  output pif_pkg::out_item_t out_item
);

  logic               v_r;
  pif_pkg::out_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= 1'b1;
    end else if (!out_stall) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= d;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

// ===== sv/probe_ie_fingerprint.sv =====
// Top level of the probe-request element fingerprint block: input register,
// parser and result register. Depends on pif_pkg, pif_parse, pif_out_stage.
//
// Takes one element byte per cycle and sustains that rate while the input
// is not stalled; a byte passes through the input register and the parser's
// one-byte CRC update into the result register, which shows the frame's
// fingerprint word once its last byte has passed. Input stalls only while a
// frame's last byte waits behind a result that the receiver has not yet taken.
module probe_ie_fingerprint (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pif_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pif_pkg::out_item_t out_item
);

  logic               s_v_r;
  pif_pkg::in_item_t  s_item_r;
  logic               fire;
  logic               in_take;
  logic               res_load;
  pif_pkg::out_item_t res;

  assign fire     = s_v_r && (!s_item_r.last_byte || !out_valid || !out_stall);
  assign in_stall = s_v_r && !fire;
  assign in_take  = in_valid && !in_stall;
  assign res_load = fire && s_item_r.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_take) begin
      s_v_r <= 1'b1;
    end else if (fire) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_item_r <= in_item;
    end
  end

  pif_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (s_item_r),
    .result (res)
  );

  pif_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .d         (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s_v_r && s_item_r.last_byte && out_valid && out_stall)
    else $error("input stalled without a blocked last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid)
    else $error("last byte produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_load)
    else $error("pending result overwritten");

endmodule
